@@ sv/dovg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dovg_pkg: shared types, constants and tables for the voice gain block
// Field widths, register codes, reset values, the gain table and the
// decimetre / log conversion helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package dovg_pkg;

    localparam int unsigned TAG_W   = 8;
    localparam int unsigned MM_W    = 20;
    localparam int unsigned DM_W    = 14;
    localparam int unsigned GAIN_W  = 15;
    localparam int unsigned LEVEL_W = 9;
    localparam int unsigned START_W = 6;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned GAP_W   = 10;
    localparam int unsigned LOG_W   = 7;
    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;

    // floor(mm / 100) as (mm * ceil(2^27 / 100)) >> 27, exact for 20-bit mm
    localparam int unsigned RECIP_W   = 21;
    localparam int unsigned DM_SHIFT  = 27;
    localparam int unsigned DM_PROD_W = MM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DM_RECIP = 21'd1342178;

    localparam logic [GAP_W-1:0]          GAP_MAX    = 10'd1023;
    localparam logic [GAIN_W-1:0]         UNITY_GAIN = 15'd16384;
    localparam logic [GAIN_W-1:0]         MAX_GAIN   = 15'd23143;
    localparam logic signed [LEVEL_W-1:0] MAX_LEVEL  = 9'sd48;
    localparam logic signed [LEVEL_W-1:0] MIN_LEVEL  = -9'sd160;

    localparam logic [MM_W-1:0]    RST_NEAR_MM  = 20'd2000;
    localparam logic [DM_W-1:0]    RST_REF_DM   = 14'd20;
    localparam logic [START_W-1:0] RST_START    = 6'd48;
    localparam logic [STEP_W-1:0]  RST_STEP     = 7'd8;

    // Log thresholds: ceil(640 * 2^(f/16)) for f = 1..15, entry 0 unused
    localparam int unsigned SCALED_W = 11;
    localparam logic [SCALED_W-1:0] LOG_THRESH [16] = '{
        11'd640,  11'd669,  11'd698,  11'd729,  11'd762,  11'd795,  11'd830,  11'd867,
        11'd906,  11'd946,  11'd988,  11'd1031, 11'd1077, 11'd1125, 11'd1174, 11'd1226
    };

    typedef enum logic [1:0] {
        REG_NEAR_THRESHOLD = 2'd0,
        REG_REF_DISTANCE   = 2'd1,
        REG_START_LEVEL    = 2'd2,
        REG_LEVEL_STEP     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MM_W-1:0]    near_threshold_mm;
        logic [DM_W-1:0]    reference_distance_dm;
        logic [START_W-1:0] start_level;
        logic [STEP_W-1:0]  level_step;
    } cfg_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [DM_W-1:0]  dm;
        logic             near;
        logic             last;
    } mid_t;

    // 16384 * 10^(level/320), rounded; level 48 and above read MAX_GAIN, the level-48 value
    function automatic logic [GAIN_W-1:0] gain_lookup(input logic [5:0] lvl);
        logic [GAIN_W-1:0] g;
        case (lvl)
            6'd0:  g = 15'd16384;
            6'd1:  g = 15'd16502;
            6'd2:  g = 15'd16621;
            6'd3:  g = 15'd16742;
            6'd4:  g = 15'd16862;
            6'd5:  g = 15'd16984;
            6'd6:  g = 15'd17107;
            6'd7:  g = 15'd17230;
            6'd8:  g = 15'd17355;
            6'd9:  g = 15'd17480;
            6'd10: g = 15'd17606;
            6'd11: g = 15'd17734;
            6'd12: g = 15'd17862;
            6'd13: g = 15'd17991;
            6'd14: g = 15'd18120;
            6'd15: g = 15'd18251;
            6'd16: g = 15'd18383;
            6'd17: g = 15'd18516;
            6'd18: g = 15'd18650;
            6'd19: g = 15'd18784;
            6'd20: g = 15'd18920;
            6'd21: g = 15'd19057;
            6'd22: g = 15'd19194;
            6'd23: g = 15'd19333;
            6'd24: g = 15'd19472;
            6'd25: g = 15'd19613;
            6'd26: g = 15'd19755;
            6'd27: g = 15'd19897;
            6'd28: g = 15'd20041;
            6'd29: g = 15'd20186;
            6'd30: g = 15'd20332;
            6'd31: g = 15'd20478;
            6'd32: g = 15'd20626;
            6'd33: g = 15'd20775;
            6'd34: g = 15'd20925;
            6'd35: g = 15'd21076;
            6'd36: g = 15'd21229;
            6'd37: g = 15'd21382;
            6'd38: g = 15'd21536;
            6'd39: g = 15'd21692;
            6'd40: g = 15'd21848;
            6'd41: g = 15'd22006;
            6'd42: g = 15'd22165;
            6'd43: g = 15'd22325;
            6'd44: g = 15'd22486;
            6'd45: g = 15'd22649;
            6'd46: g = 15'd22812;
            6'd47: g = 15'd22977;
            default: g = MAX_GAIN;
        endcase
        return g;
    endfunction

    // floor(16 * log2((gap + 10) / 10)): octave from a compare chain, then the
    // sixteenth within the octave from the operand scaled into [640, 1280)
    function automatic logic [LOG_W-1:0] log_value(input logic [GAP_W-1:0] gap);
        logic [SCALED_W-1:0] m;
        logic [SCALED_W-1:0] scaled;
        logic [2:0]          oct;
        logic [3:0]          frac;
        m = SCALED_W'(gap) + 11'd10;
        oct = 3'd0;
        if (m >= 11'd20)  oct = 3'd1;
        if (m >= 11'd40)  oct = 3'd2;
        if (m >= 11'd80)  oct = 3'd3;
        if (m >= 11'd160) oct = 3'd4;
        if (m >= 11'd320) oct = 3'd5;
        if (m >= 11'd640) oct = 3'd6;
        scaled = m << (3'd6 - oct);
        frac = 4'd0;
        for (int f = 1; f < 16; f++)
        begin
            if (scaled >= LOG_THRESH[4'(f)])
            begin
                frac = 4'(f);
            end
        end
        return {oct, frac};
    endfunction

endpackage
`default_nettype wire

@@ sv/dovg_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dovg_cfg: APB register file
// Holds the near threshold, reference distance, start level and level step,
// with zero-wait writes and combinational read data.
// ----------------------------------------------------------------------------
module dovg_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dovg_pkg::APB_AW-1:0]   paddr,
    input  wire logic [dovg_pkg::APB_DW-1:0]   pwdata,
    output logic      [dovg_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output dovg_pkg::cfg_t                     cfg
);

    dovg_pkg::reg_idx_t idx;
    logic               wr_en;
    dovg_pkg::cfg_t     cfg_reg;

    assign idx    = dovg_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold_mm     <= dovg_pkg::RST_NEAR_MM;
            cfg_reg.reference_distance_dm <= dovg_pkg::RST_REF_DM;
            cfg_reg.start_level           <= dovg_pkg::RST_START;
            cfg_reg.level_step            <= dovg_pkg::RST_STEP;
        end
        else if (wr_en)
        begin
            case (idx)
                dovg_pkg::REG_NEAR_THRESHOLD:
                    cfg_reg.near_threshold_mm <= pwdata[dovg_pkg::MM_W-1:0];
                dovg_pkg::REG_REF_DISTANCE:
                    cfg_reg.reference_distance_dm <= pwdata[dovg_pkg::DM_W-1:0];
                dovg_pkg::REG_START_LEVEL:
                    cfg_reg.start_level <= pwdata[dovg_pkg::START_W-1:0];
                dovg_pkg::REG_LEVEL_STEP:
                    cfg_reg.level_step <= pwdata[dovg_pkg::STEP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dovg_pkg::REG_NEAR_THRESHOLD:
                prdata = dovg_pkg::APB_DW'(cfg_reg.near_threshold_mm);
            dovg_pkg::REG_REF_DISTANCE:
                prdata = dovg_pkg::APB_DW'(cfg_reg.reference_distance_dm);
            dovg_pkg::REG_START_LEVEL:
                prdata = dovg_pkg::APB_DW'(cfg_reg.start_level);
            dovg_pkg::REG_LEVEL_STEP:
                prdata = dovg_pkg::APB_DW'(cfg_reg.level_step);
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/dovg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dovg_front: input register and decimetre conversion
// Registers each voice item, converts millimetres to decimetres by a
// reciprocal multiply and flags near voices into the middle register.
// ----------------------------------------------------------------------------
module dovg_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        voice_valid,
    output logic                             voice_ready,
    input  wire logic [dovg_pkg::TAG_W-1:0]  voice_index,
    input  wire logic [dovg_pkg::MM_W-1:0]   distance_mm,
    input  wire logic                        last_in_frame,
    input  wire logic [dovg_pkg::MM_W-1:0]   near_threshold_mm,
    output logic                             mid_valid,
    input  wire logic                        mid_ready,
    output dovg_pkg::mid_t                   mid
);

    logic                          in_valid_reg;
    logic [dovg_pkg::TAG_W-1:0]    in_tag_reg;
    logic [dovg_pkg::MM_W-1:0]     in_mm_reg;
    logic                          in_last_reg;
    logic                          mid_valid_reg;
    dovg_pkg::mid_t                mid_reg;
    dovg_pkg::mid_t                mid_next;
    logic [dovg_pkg::DM_PROD_W-1:0] dm_prod;
    logic                          move;
    logic                          take;

    // move the input item on when the middle slot is free or draining
    assign move        = in_valid_reg && (!mid_valid_reg || mid_ready);
    assign voice_ready = !in_valid_reg || move;
    assign take        = voice_valid && voice_ready;

    assign dm_prod = dovg_pkg::DM_PROD_W'(in_mm_reg) *
                     dovg_pkg::DM_PROD_W'(dovg_pkg::DM_RECIP);

    always_comb
    begin
        mid_next.tag  = in_tag_reg;
        mid_next.dm   = dm_prod[dovg_pkg::DM_PROD_W-1:dovg_pkg::DM_SHIFT];
        mid_next.near = (in_mm_reg <= near_threshold_mm);
        mid_next.last = in_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                in_valid_reg <= 1'b0;
            end
            if (move)
            begin
                mid_valid_reg <= 1'b1;
            end
            else if (mid_ready)
            begin
                mid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_tag_reg  <= voice_index;
            in_mm_reg   <= distance_mm;
            in_last_reg <= last_in_frame;
        end
        if (move)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule
`default_nettype wire

@@ sv/dovg_level.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dovg_level: running level, gain lookup and result register
// Keeps the frame state (level and previous far distance), turns the gap
// into a log step, picks the gain and registers the result item.
// ----------------------------------------------------------------------------
module dovg_level (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dovg_pkg::cfg_t               cfg,
    input  wire logic                         mid_valid,
    output logic                              mid_ready,
    input  wire dovg_pkg::mid_t               mid,
    output logic                              gain_valid,
    input  wire logic                         gain_ready,
    output logic [dovg_pkg::TAG_W-1:0]        voice_tag,
    output logic [dovg_pkg::GAIN_W-1:0]       gain_q14,
    output logic                              frame_end
);

    logic signed [dovg_pkg::LEVEL_W-1:0] level_reg;
    logic signed [dovg_pkg::LEVEL_W-1:0] level_next;
    logic [dovg_pkg::DM_W-1:0]           last_dm_reg;
    logic [dovg_pkg::DM_W-1:0]           last_dm_next;
    logic                                out_valid_reg;
    logic [dovg_pkg::TAG_W-1:0]          tag_reg;
    logic [dovg_pkg::GAIN_W-1:0]         gain_reg;
    logic [dovg_pkg::GAIN_W-1:0]         gain_next;
    logic                                end_reg;
    logic                                take;
    logic [dovg_pkg::DM_W-1:0]           gap_full;
    logic [dovg_pkg::GAP_W-1:0]          gap;
    logic [dovg_pkg::LOG_W-1:0]          log_step;
    logic [dovg_pkg::LEVEL_W:0]          lv_raw;
    logic [dovg_pkg::LEVEL_W:0]          min_ext;
    logic signed [dovg_pkg::LEVEL_W-1:0] lv_clamped;
    logic signed [dovg_pkg::LEVEL_W-1:0] start_sat;

    assign mid_ready = !out_valid_reg || gain_ready;
    assign take      = mid_valid && mid_ready;

    always_comb
    begin
        gap_full = (mid.dm > last_dm_reg) ? (mid.dm - last_dm_reg) : '0;
        gap      = (gap_full > dovg_pkg::DM_W'(dovg_pkg::GAP_MAX)) ?
                   dovg_pkg::GAP_MAX : gap_full[dovg_pkg::GAP_W-1:0];
        log_step = dovg_pkg::log_value(gap);

        // drop by step plus log, floor at the bottom level
        lv_raw  = {level_reg[dovg_pkg::LEVEL_W-1], level_reg}
                  - (dovg_pkg::LEVEL_W+1)'(cfg.level_step)
                  - (dovg_pkg::LEVEL_W+1)'(log_step);
        min_ext = {dovg_pkg::MIN_LEVEL[dovg_pkg::LEVEL_W-1], dovg_pkg::MIN_LEVEL};
        lv_clamped = ($signed(lv_raw) < $signed(min_ext)) ?
                     dovg_pkg::MIN_LEVEL : lv_raw[dovg_pkg::LEVEL_W-1:0];

        start_sat = (cfg.start_level > dovg_pkg::START_W'(dovg_pkg::MAX_LEVEL)) ?
                    dovg_pkg::MAX_LEVEL : dovg_pkg::LEVEL_W'(cfg.start_level);

        if (mid.near)
        begin
            gain_next = dovg_pkg::UNITY_GAIN;
        end
        else if (level_reg[dovg_pkg::LEVEL_W-1])
        begin
            gain_next = '0;
        end
        else
        begin
            gain_next = dovg_pkg::gain_lookup(level_reg[5:0]);
        end

        if (mid.last)
        begin
            level_next   = start_sat;
            last_dm_next = cfg.reference_distance_dm;
        end
        else if (mid.near)
        begin
            level_next   = level_reg;
            last_dm_next = last_dm_reg;
        end
        else
        begin
            level_next   = lv_clamped;
            last_dm_next = mid.dm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            level_reg     <= dovg_pkg::LEVEL_W'(dovg_pkg::RST_START);
            last_dm_reg   <= dovg_pkg::RST_REF_DM;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                level_reg     <= level_next;
                last_dm_reg   <= last_dm_next;
            end
            else if (gain_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tag_reg  <= mid.tag;
            gain_reg <= gain_next;
            end_reg  <= mid.last;
        end
    end

    assign gain_valid = out_valid_reg;
    assign voice_tag  = tag_reg;
    assign gain_q14   = gain_reg;
    assign frame_end  = end_reg;

    a_reload_dist: assert property (@(posedge clk) disable iff (!rst_n)
        take && mid.last |=> last_dm_reg == $past(cfg.reference_distance_dm))
        else $error("previous distance not reloaded at frame end");

    a_near_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        take && mid.near && !mid.last |=> $stable(level_reg) && $stable(last_dm_reg))
        else $error("near voice changed the frame state");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> ($signed(level_reg) >= $signed(dovg_pkg::MIN_LEVEL)) &&
                 ($signed(level_reg) <= $signed(dovg_pkg::MAX_LEVEL)))
        else $error("running level left its range");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg && gain_reg <= dovg_pkg::MAX_GAIN)
        else $error("result missing or gain above table top");

endmodule
`default_nettype wire

@@ sv/distance_ordered_voice_gain_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: a voice item goes from the input register through the decimetre
// register to the result register. Throughput: one item per cycle while
// gain_ready is high; the frame state updates in the result stage.
// Reset: registers return to their defaults, the frame state loads from them,
// and all pipeline stages come up empty; no clearing pass.
// ----------------------------------------------------------------------------
// distance_ordered_voice_gain_top: distance-ordered voice gain
// Assigns a Q1.14 gain to each voice of a frame from a running level that
// drops by the level step plus the log of the distance gap between successive
// far voices.
module distance_ordered_voice_gain_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dovg_pkg::APB_AW-1:0]   paddr,
    input  wire logic [dovg_pkg::APB_DW-1:0]   pwdata,
    output logic      [dovg_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          voice_valid,
    output logic                               voice_ready,
    input  wire logic [dovg_pkg::TAG_W-1:0]    voice_index,
    input  wire logic [dovg_pkg::MM_W-1:0]     distance_mm,
    input  wire logic                          last_in_frame,
    output logic                               gain_valid,
    input  wire logic                          gain_ready,
    output logic [dovg_pkg::TAG_W-1:0]         voice_tag,
    output logic [dovg_pkg::GAIN_W-1:0]        gain_q14,
    output logic                               frame_end
);

    dovg_pkg::cfg_t cfg;
    dovg_pkg::mid_t mid;
    logic           mid_valid;
    logic           mid_ready;

    dovg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dovg_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .voice_valid       (voice_valid),
        .voice_ready       (voice_ready),
        .voice_index       (voice_index),
        .distance_mm       (distance_mm),
        .last_in_frame     (last_in_frame),
        .near_threshold_mm (cfg.near_threshold_mm),
        .mid_valid         (mid_valid),
        .mid_ready         (mid_ready),
        .mid               (mid)
    );

    dovg_level u_level (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .mid_valid  (mid_valid),
        .mid_ready  (mid_ready),
        .mid        (mid),
        .gain_valid (gain_valid),
        .gain_ready (gain_ready),
        .voice_tag  (voice_tag),
        .gain_q14   (gain_q14),
        .frame_end  (frame_end)
    );

endmodule
`default_nettype wire
